// ===== src/insort_pkg.sv =====
// shared payload types for the insertion sorter
package insort_pkg;

  localparam int unsigned ValueW = 16;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              final_req;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] sorted_value;
    logic              last_out;
    logic              overflow;
  } out_item_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              greater;
  } cell_link_t;

endpackage

// ===== src/insort_cell.sv =====
// one compare-and-shift cell of the sorting chain
module insort_cell
  import insort_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 ins_en_i,
  input  logic                 shift_en_i,
  input  logic [ValueW-1:0]    ins_value_i,
  input  logic                 valid_i,
  input  cell_link_t           left_i,
  input  logic [ValueW-1:0]    right_value_i,
  output cell_link_t           link_o
);

  logic [ValueW-1:0] value_d, value_q;
  logic              greater;

  // an empty cell counts as larger than any value
  assign greater = !valid_i || (value_q > ins_value_i);

  always_comb begin
    value_d = value_q;
    if (ins_en_i) begin
      if (greater) begin
        value_d = left_i.greater ? left_i.value : ins_value_i;
      end
    end else if (shift_en_i) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.value   = value_q;
  assign link_o.greater = greater;

endmodule

// ===== src/insertion_sorter_unit.sv =====
// streaming insertion sorter built from a chain of compare-and-shift cells
//
//   channel | signals                           | payload
//   --------+-----------------------------------+-------------------------------
//   in      | in_valid_i / in_ready_o           | in_data_i  (value, final_req)
//   out     | out_valid_o / out_ready_i         | out_data_o (sorted_value,
//           |                                   |   last_out, overflow)
//
// - on an insert every cell compares against the new value in parallel and
//   the larger ones move one place right
// - a set drains one value per cycle from cell 0 while the output register is
//   taken every cycle; each output stall holds the chain
// - the input is not ready while a set drains, from the cycle after the final
//   transaction until its last value sits in the output register
// - reset clears the fill count, the drain state, the drop and overflow flags
//   and the output valid; cell contents are only read below the fill count and need no reset
module insertion_sorter_unit
  import insort_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // control state
  logic [CntW-1:0] fill_d, fill_q;
  logic            drain_d, drain_q;
  logic            dropped_d, dropped_q;
  logic            ovf_d, ovf_q;
  logic            out_valid_d, out_valid_q;
  out_item_t       out_d, out_q;

  logic in_fire, full, ins_en, shift_en, last_one;

  cell_link_t                  links [DEPTH];
  logic       [DEPTH-1:0]      cell_valid;

  assign in_ready_o = !drain_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (fill_q == CntW'(DEPTH));
  // a value that finds the store full is dropped
  assign ins_en     = in_fire && !full;
  // drain moves one value out whenever the output register is free
  assign shift_en   = drain_q && (!out_valid_q || out_ready_i);
  assign last_one   = (fill_q == CntW'(1));

  // the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t          left;
    logic [ValueW-1:0]   right_value;

    assign cell_valid[i] = (fill_q > CntW'(i));

    if (i == 0) begin : g_head
      // nothing to the left: a new value lands here when the cell is larger
      assign left.value   = '0;
      assign left.greater = 1'b0;
    end else begin : g_body
      assign left = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = links[i].value;
    end else begin : g_inner
      assign right_value = links[i+1].value;
    end

    insort_cell u_cell (
      .clk_i         (clk_i),
      .ins_en_i      (ins_en),
      .shift_en_i    (shift_en),
      .ins_value_i   (in_data_i.value),
      .valid_i       (cell_valid[i]),
      .left_i        (left),
      .right_value_i (right_value),
      .link_o        (links[i])
    );
  end

  always_comb begin
    fill_d      = fill_q;
    drain_d     = drain_q;
    dropped_d   = dropped_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (in_fire) begin
      if (ins_en) begin
        fill_d = fill_q + CntW'(1);
      end
      if (in_data_i.final_req) begin
        // freeze the overflow flag for this set and start draining
        ovf_d     = dropped_q || full;
        dropped_d = 1'b0;
        drain_d   = 1'b1;
      end else if (full) begin
        dropped_d = 1'b1;
      end
    end

    if (shift_en) begin
      out_d.sorted_value = links[0].value;
      out_d.last_out     = last_one;
      out_d.overflow     = ovf_q;
      out_valid_d        = 1'b1;
      fill_d             = fill_q - CntW'(1);
      if (last_one) begin
        drain_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      drain_q     <= 1'b0;
      dropped_q   <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      drain_q     <= drain_d;
      dropped_q   <= dropped_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fill count stays within the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  // a draining set always has a value in cell 0
  assert property (@(posedge clk_i) disable iff (!rst_ni) drain_q |-> fill_q != '0)
    else $error("drain with empty chain");

  // moving the last value out ends the drain and flags it as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (shift_en && last_one) |=> (!drain_q && out_valid_o && out_data_o.last_out))
    else $error("drain did not close on last value");

endmodule
